### hw/rtl/kmp_pkg.sv
package kmp_pkg;

    // Pattern capacity and width of the text position counter.
    localparam int MAX_PATTERN   = 256;
    localparam int POSITION_BITS = 32;

    // Derived widths: index into the pattern, and a length that can hold MAX_PATTERN.
    localparam int IDX_W = $clog2(MAX_PATTERN);
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    // Widths of the result fields as they leave the block.
    localparam int MATCH_POS_W   = 32;
    localparam int PAT_LENGTH_W  = 9;
    localparam int DATA_BYTE_W   = 8;
    localparam int REQ_TYPE_W    = 2;

    // Depth of the command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_TEXT   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_SAT   = 2'd3
    } status_t;

    typedef struct packed {
        req_t                   req;
        logic [DATA_BYTE_W-1:0] data;
    } cmd_t;

    // Packed from the top bit down, so found lands in bit 0.
    typedef struct packed {
        status_t                 status;
        logic [PAT_LENGTH_W-1:0] pat_len;
        logic [MATCH_POS_W-1:0]  match_position;
        logic                    found;
    } result_t;

    localparam int RESULT_W    = $bits(result_t);
    localparam int M_TDATA_W   = ((RESULT_W + 7) / 8) * 8;

endpackage

### hw/rtl/kmp_front.sv
module kmp_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [kmp_pkg::DATA_BYTE_W-1:0]   s_tdata,
    input  logic [kmp_pkg::REQ_TYPE_W-1:0]    s_tuser,
    output logic                              cmd_valid,
    output kmp_pkg::cmd_t                     cmd,
    input  logic                              cmd_pop
);
    import kmp_pkg::*;

    cmd_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    cmd_t              cmd_in;

    // Classify the incoming word into a command.
    always_comb begin
        cmd_in.req  = req_t'(s_tuser);
        cmd_in.data = s_tdata;
    end

    assign s_tready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (cmd_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && cmd_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("command queue count out of range");

endmodule

### hw/rtl/kmp_back.sv
module kmp_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    input  kmp_pkg::cmd_t     cmd,
    output logic              cmd_pop,
    input  logic              res_ready,
    output logic              res_valid,
    output kmp_pkg::result_t  res
);
    import kmp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EVAL = 2'b10
    } state_t;

    state_t                   state_reg, state_next;
    logic [LEN_W-1:0]         stored_len_reg, stored_len_next;
    logic [LEN_W-1:0]         matched_reg, matched_next;
    logic [POSITION_BITS-1:0] text_idx_reg, text_idx_next;
    logic                     found_reg, found_next;
    logic [POSITION_BITS-1:0] found_pos_reg, found_pos_next;
    logic [IDX_W-1:0]         last_link_reg, last_link_next;
    logic [LEN_W-1:0]         k_reg, k_next;
    logic                     is_append_reg, is_append_next;
    logic [DATA_BYTE_W-1:0]   byte_reg, byte_next;
    logic                     out_valid_reg, out_valid_next;
    result_t                  out_reg, out_next;

    logic [DATA_BYTE_W-1:0]   pat_mem  [MAX_PATTERN];
    logic [IDX_W-1:0]         link_mem [MAX_PATTERN];
    logic [DATA_BYTE_W-1:0]   pat_q;
    logic [IDX_W-1:0]         link_q;
    logic [IDX_W-1:0]         pat_rd_addr, link_rd_addr;

    logic                     mem_we;
    logic [IDX_W-1:0]         mem_wr_addr;
    logic [DATA_BYTE_W-1:0]   mem_wr_pat;
    logic [IDX_W-1:0]         mem_wr_link;

    logic                     out_free;
    logic                     emit;
    status_t                  emit_status;
    logic                     hit;
    logic [LEN_W-1:0]         k_final;

    assign out_free = !out_valid_reg || res_ready;
    assign cmd_pop  = (state_reg == ST_IDLE) && cmd_valid && out_free;
    assign hit      = (pat_q == byte_reg);
    assign k_final  = hit ? (k_reg + 1'b1) : k_reg;

    always_comb begin
        state_next     = state_reg;
        stored_len_next = stored_len_reg;
        matched_next   = matched_reg;
        text_idx_next  = text_idx_reg;
        found_next     = found_reg;
        found_pos_next = found_pos_reg;
        last_link_next = last_link_reg;
        k_next         = k_reg;
        is_append_next = is_append_reg;
        byte_next      = byte_reg;
        mem_we         = 1'b0;
        mem_wr_addr    = stored_len_reg[IDX_W-1:0];
        mem_wr_pat     = byte_reg;
        mem_wr_link    = k_final[IDX_W-1:0];
        emit           = 1'b0;
        emit_status    = STAT_OK;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_pop) begin
                    byte_next = cmd.data;
                    case (cmd.req)
                        REQ_CLEAR: begin
                            stored_len_next = '0;
                            matched_next    = '0;
                            text_idx_next   = '0;
                            found_next      = 1'b0;
                            found_pos_next  = '0;
                            emit            = 1'b1;
                        end
                        REQ_APPEND: begin
                            if (stored_len_reg >= LEN_W'(MAX_PATTERN)) begin
                                emit        = 1'b1;
                                emit_status = STAT_FULL;
                            end else if (stored_len_reg == '0) begin
                                // The first byte has no border.
                                mem_we          = 1'b1;
                                mem_wr_pat      = cmd.data;
                                mem_wr_link     = '0;
                                stored_len_next = LEN_W'(1);
                                last_link_next  = '0;
                                matched_next    = '0;
                                text_idx_next   = '0;
                                found_next      = 1'b0;
                                found_pos_next  = '0;
                                emit            = 1'b1;
                            end else begin
                                k_next         = {1'b0, last_link_reg};
                                is_append_next = 1'b1;
                                state_next     = ST_EVAL;
                            end
                        end
                        REQ_TEXT: begin
                            if (stored_len_reg == '0) begin
                                emit        = 1'b1;
                                emit_status = STAT_EMPTY;
                            end else if (found_reg) begin
                                emit = 1'b1;
                            end else if (&text_idx_reg) begin
                                emit        = 1'b1;
                                emit_status = STAT_SAT;
                            end else begin
                                k_next = (matched_reg >= stored_len_reg) ? '0 : matched_reg;
                                is_append_next = 1'b0;
                                state_next     = ST_EVAL;
                            end
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_EVAL: begin
                if (!hit && (k_reg != '0)) begin
                    // Follow the failure link; the next memory read uses it.
                    k_next = {1'b0, link_q};
                end else begin
                    state_next = ST_IDLE;
                    emit       = 1'b1;
                    if (is_append_reg) begin
                        mem_we          = 1'b1;
                        stored_len_next = stored_len_reg + 1'b1;
                        last_link_next  = k_final[IDX_W-1:0];
                        matched_next    = '0;
                        text_idx_next   = '0;
                        found_next      = 1'b0;
                        found_pos_next  = '0;
                    end else begin
                        matched_next  = k_final;
                        text_idx_next = text_idx_reg + 1'b1;
                        if (k_final == stored_len_reg) begin
                            found_next     = 1'b1;
                            found_pos_next = text_idx_reg + 1'b1
                                             - POSITION_BITS'(stored_len_reg);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register toward the output channel.
    always_comb begin
        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;
        if (emit) begin
            out_valid_next         = 1'b1;
            out_next.found         = found_next;
            out_next.match_position = found_next ? MATCH_POS_W'(found_pos_next) : '0;
            out_next.pat_len       = PAT_LENGTH_W'(stored_len_next);
            out_next.status        = emit_status;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    assign pat_rd_addr  = k_next[IDX_W-1:0];
    assign link_rd_addr = IDX_W'(k_next - 1'b1);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pat_mem[mem_wr_addr]  <= mem_wr_pat;
            link_mem[mem_wr_addr] <= mem_wr_link;
        end
        pat_q  <= pat_mem[pat_rd_addr];
        link_q <= link_mem[link_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            stored_len_reg <= '0;
            matched_reg    <= '0;
            text_idx_reg   <= '0;
            found_reg      <= 1'b0;
            found_pos_reg  <= '0;
            k_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            stored_len_reg <= stored_len_next;
            matched_reg    <= matched_next;
            text_idx_reg   <= text_idx_next;
            found_reg      <= found_next;
            found_pos_reg  <= found_pos_next;
            k_reg          <= k_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_link_reg <= last_link_next;
        is_append_reg <= is_append_next;
        byte_reg      <= byte_next;
        out_reg       <= out_next;
    end

    // A command only enters the engine once the result register is free.
    a_eval_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL) |-> !out_valid_reg)
        else $error("engine busy while a result word is still pending");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stored_len_reg <= LEN_W'(MAX_PATTERN))
        else $error("stored pattern length exceeds capacity");

    a_found_needs_pattern: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> (stored_len_reg != '0))
        else $error("match flagged without a stored pattern");

    a_partial_match: assert property (@(posedge aclk) disable iff (!aresetn)
        !found_reg |-> ((matched_reg < stored_len_reg) || (matched_reg == '0)))
        else $error("partial match length reached the pattern length");

endmodule

### hw/rtl/kmp_stream_matcher.sv
// Streaming Knuth-Morris-Pratt matcher that finds the first occurrence of a stored
// pattern in a byte stream.
// Input channel (s_): s_tuser carries the request kind (0 clear, 1 append a pattern
// byte, 2 text byte, 3 no operation) and s_tdata carries the byte. Every accepted word
// yields exactly one result word on the output channel (m_), in order.
// The result word reports the found flag, the start position of the first match, the
// number of stored pattern bytes and a status (ok, pattern full, empty pattern,
// position saturated). Appending a byte, unless the pattern is full, restarts text matching.
// An accepted word enters a two-entry command queue. Clear, no-op, rejected words and the
// first pattern byte go from the queue straight into the result register, and the engine
// can take one of them per cycle while that register is free. A text byte or a later
// pattern byte first reads the pattern and failure-link memories and then takes one more
// read for each failure-link step before its result is registered; these steps are
// amortized to at most one per byte. The pace is set by the single read port of the
// pattern and failure-link memories, which is visited once per step.
// Reset (aresetn low, synchronous) empties the pattern, the match state and the queue.
// The pattern memory needs no clearing pass, since only written entries are read.
// When the receiver stalls, the result stays in the output register, the engine
// stops before its next word and the queue absorbs up to two further input words.
module kmp_stream_matcher (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: [7:0] data_byte
    input  logic [kmp_pkg::DATA_BYTE_W-1:0]  s_tdata,
    // s_tuser: [1:0] req_type
    input  logic [kmp_pkg::REQ_TYPE_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: [0] found, [32:1] match_position, [41:33] pat_len,
    // [43:42] status, [47:44] zero
    output logic [kmp_pkg::M_TDATA_W-1:0]    m_tdata
);
    import kmp_pkg::*;

    logic    cmd_valid;
    cmd_t    cmd;
    logic    cmd_pop;
    result_t res;

    // Front: accepts words, decodes the request kind and queues the command.
    kmp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Back: walks failure links in the pattern memories and registers the result.
    kmp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_ready (m_tready),
        .res_valid (m_tvalid),
        .res       (res)
    );

    // Result fields packed from bit 0 upward, padded with zeros to whole bytes.
    assign m_tdata = M_TDATA_W'(res);

endmodule

### tb/kmp_result_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the matcher. Every accepted input word is run through a
// private copy of the search state, which queues the result word that must come back.
// Every accepted result word is checked against the oldest queued one.
module kmp_result_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [kmp_pkg::DATA_BYTE_W-1:0] s_tdata,
    input  logic [kmp_pkg::REQ_TYPE_W-1:0]  s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [kmp_pkg::M_TDATA_W-1:0]   m_tdata,
    output int                              mismatch_count,
    output int                              results_owed
);
    import kmp_pkg::*;

    localparam logic [63:0] POS_LIMIT = (64'd1 << POSITION_BITS) - 64'd1;

    // Search state: stored pattern, border length of each prefix, and text progress.
    logic [7:0]  pat_bytes  [MAX_PATTERN];
    int unsigned border_len [MAX_PATTERN];
    int unsigned pat_count;
    int unsigned run_len;
    logic [63:0] text_pos;
    logic [63:0] hit_pos;
    logic        hit;

    result_t     awaited_results [$];
    int          fail_tally = 0;

    task automatic restart_search();
        run_len  = 0;
        text_pos = '0;
        hit      = 1'b0;
        hit_pos  = '0;
    endtask

    // Applies one input word to the search state and queues the word it must produce.
    task automatic take_word(input req_t kind, input logic [7:0] value);
        int unsigned j;
        status_t     stat;
        result_t     want;
        stat = STAT_OK;
        case (kind)
            REQ_CLEAR: begin
                pat_count = 0;
                restart_search();
            end
            REQ_APPEND: begin
                if (pat_count >= MAX_PATTERN) begin
                    stat = STAT_FULL;
                end else begin
                    j = 0;
                    if (pat_count != 0) begin
                        // Walk the borders of the current pattern until one extends.
                        j = border_len[pat_count - 1];
                        while (j > 0 && pat_bytes[j] != value)
                            j = border_len[j - 1];
                        if (pat_bytes[j] == value)
                            j++;
                    end
                    pat_bytes[pat_count]  = value;
                    border_len[pat_count] = j;
                    pat_count++;
                    restart_search();
                end
            end
            REQ_TEXT: begin
                if (pat_count == 0) begin
                    stat = STAT_EMPTY;
                end else if (!hit) begin
                    if (text_pos >= POS_LIMIT) begin
                        stat = STAT_SAT;
                    end else begin
                        j = (run_len >= pat_count) ? 0 : run_len;
                        while (j > 0 && pat_bytes[j] != value)
                            j = border_len[j - 1];
                        if (pat_bytes[j] == value)
                            j++;
                        if (j == pat_count) begin
                            hit     = 1'b1;
                            hit_pos = text_pos + 64'd1 - 64'(pat_count);
                        end
                        run_len  = j;
                        text_pos = text_pos + 64'd1;
                    end
                end
            end
            default: ;
        endcase
        want.found          = hit;
        want.match_position = hit ? hit_pos[MATCH_POS_W-1:0] : '0;
        want.pat_len        = pat_count[PAT_LENGTH_W-1:0];
        want.status         = stat;
        awaited_results.push_back(want);
    endtask

    function automatic int field_differs(string field, logic [63:0] want, logic [63:0] got);
        if (got === want)
            return 0;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        return 1;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (!aresetn) begin
            pat_count = 0;
            restart_search();
            awaited_results.delete();
        end else begin
            if (s_tvalid && s_tready)
                take_word(req_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[RESULT_W-1:0]);
                if (awaited_results.size() == 0) begin
                    $display("%0t: result word with none expected, expected nothing, actual 0x%0h",
                             $time, m_tdata);
                    fail_tally++;
                end else begin
                    want = awaited_results.pop_front();
                    fail_tally += field_differs("found", 64'(want.found), 64'(got.found));
                    fail_tally += field_differs("match_position", 64'(want.match_position),
                                                64'(got.match_position));
                    fail_tally += field_differs("pat_len", 64'(want.pat_len),
                                                64'(got.pat_len));
                    fail_tally += field_differs("status", 64'(want.status), 64'(got.status));
                    fail_tally += field_differs("padding", 64'd0,
                                                64'(m_tdata[M_TDATA_W-1:RESULT_W]));
                end
            end
        end
        mismatch_count <= fail_tally;
        results_owed   <= awaited_results.size();
    end

endmodule

### tb/kmp_stream_matcher_test.sv
`timescale 1ns / 1ps

// Drives the matcher with pattern and text words and gives the verdict. The checker
// beside the block predicts each result word and counts mismatches.
module kmp_stream_matcher_test;
    import kmp_pkg::*;

    localparam int RANDOM_WORDS = 1900;
    localparam int CYCLE_LIMIT  = 800000;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [DATA_BYTE_W-1:0] s_tdata  = '0;
    logic [REQ_TYPE_W-1:0]  s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    int mismatch_count;
    int results_owed;
    int cycle_count  = 0;
    int stall_left   = 0;
    int words_counted = 0;
    bit quiet_phase  = 1'b0;

    kmp_stream_matcher uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    kmp_result_checker result_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: after each accepted result word it stalls for a random number of cycles,
    // except in quiet stretches where it stays ready.
    always @(posedge aclk) begin
        int hold;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (m_tready && m_tvalid) begin
            hold = quiet_phase ? 0 : $urandom_range(0, 16);
            if (hold == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready   <= 1'b0;
                stall_left <= hold - 1;
            end
        end else if (!m_tready) begin
            if (stall_left == 0)
                m_tready <= 1'b1;
            else
                stall_left <= stall_left - 1;
        end
    end

    // Presents one word after a random gap and returns at the edge that accepts it.
    // The valid stays high on return, so the caller must drop it before any pause.
    task automatic send_word(input req_t kind, input logic [7:0] value);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        if (kind != REQ_NONE)
            words_counted++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
    endtask

    initial begin
        logic [7:0] alpha [4];
        logic [7:0] pat [8];
        logic [1:0] raw_kind;
        int         asz;
        int         plen;
        int         tlen;
        int         plant_at;
        int         seq_kind;
        int         n;
        bit         planted;
        bit         filled;

        filled = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words: text with no pattern, the unused request code, a pattern with
        // nested borders found in the text, text after the match, an append that restarts
        // the search, and text after a clear.
        send_word(REQ_TEXT, 8'hFF);
        send_word(REQ_NONE, 8'hA5);
        send_word(REQ_CLEAR, 8'h00);
        send_word(REQ_APPEND, 8'h00);
        send_word(REQ_APPEND, 8'hFF);
        send_word(REQ_APPEND, 8'h00);
        send_word(REQ_APPEND, 8'hFF);
        send_word(REQ_APPEND, 8'h00);
        for (int i = 0; i < 6; i++)
            send_word(REQ_TEXT, (i % 2 == 0) ? 8'hFF : 8'h00);
        send_word(REQ_TEXT, 8'h00);
        send_word(REQ_NONE, 8'h5A);
        send_word(REQ_APPEND, 8'h80);
        send_word(REQ_TEXT, 8'h00);
        send_word(REQ_CLEAR, 8'hFF);
        send_word(REQ_TEXT, 8'h01);

        // The saturated position case would need 2^32 text words and is not reached.
        words_counted = 0;
        while (words_counted < RANDOM_WORDS) begin
            seq_kind    = $urandom_range(0, 99);
            quiet_phase = ($urandom_range(0, 5) == 0);
            asz = $urandom_range(1, 4);
            for (int i = 0; i < 4; i++)
                alpha[i] = 8'($urandom_range(0, 255));
            if (!filled && words_counted >= RANDOM_WORDS / 2)
                seq_kind = 100;

            if (seq_kind == 100) begin
                // Fill the pattern to capacity, push past it, then search a little.
                filled   = 1'b1;
                alpha[1] = ~alpha[0];
                send_word(REQ_CLEAR, alpha[0]);
                for (int i = 0; i < MAX_PATTERN + 2; i++)
                    send_word(REQ_APPEND, alpha[$urandom_range(0, 1)]);
                for (int i = 0; i < 20; i++)
                    send_word(REQ_TEXT, alpha[$urandom_range(0, 1)]);
                drain_results();
            end else if (seq_kind < 70) begin
                // Short pattern over a small alphabet, then text that often holds a copy.
                plen = $urandom_range(1, 8);
                if ($urandom_range(0, 4) != 0)
                    send_word(REQ_CLEAR, 8'($urandom_range(0, 255)));
                for (int i = 0; i < plen; i++) begin
                    pat[i] = alpha[$urandom_range(0, asz - 1)];
                    send_word(REQ_APPEND, pat[i]);
                end
                tlen     = $urandom_range(4, 40);
                plant_at = $urandom_range(0, tlen - 1);
                planted  = ($urandom_range(0, 2) != 0);
                for (int i = 0; i < tlen; i++) begin
                    if (planted && i >= plant_at && i < plant_at + plen)
                        send_word(REQ_TEXT, pat[i - plant_at]);
                    else
                        send_word(REQ_TEXT, alpha[$urandom_range(0, asz - 1)]);
                end
            end else if (seq_kind < 85) begin
                // Noise: any request code with any byte.
                n = $urandom_range(5, 15);
                for (int i = 0; i < n; i++) begin
                    raw_kind = 2'($urandom_range(0, 3));
                    send_word(req_t'(raw_kind), 8'($urandom_range(0, 255)));
                end
            end else begin
                // Appends interleaved with text, so the search restarts mid-stream.
                n = $urandom_range(5, 20);
                for (int i = 0; i < n; i++)
                    send_word(($urandom_range(0, 3) == 0) ? REQ_APPEND : REQ_TEXT,
                              alpha[$urandom_range(0, asz - 1)]);
            end

            if ($urandom_range(0, 7) == 0)
                drain_results();
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
